/* rtl/dcs_pkg.sv */
// Shared constants, state encoding and unit interface structs for the
// divisor count and sum block. Used by every module under rtl/.
package dcs_pkg;

   localparam int NUMBER_BITS = 31;
   localparam int NUM_IN_W    = 31;
   localparam int COUNT_OUT_W = 11;
   localparam int SUM_OUT_W   = 34;

   // most internal widths follow from the factored width
   localparam int SUM_W     = NUMBER_BITS + 4;
   localparam int SQ_W      = NUMBER_BITS + 2;
   localparam int CNT_W     = 16;
   localparam int K_W       = $clog2(NUMBER_BITS + 1);
   localparam int DIV_CNT_W = $clog2(NUMBER_BITS);
   localparam int WIDE_W    = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

   localparam logic [COUNT_OUT_W-1:0] COUNT_MAX = '1;
   localparam logic [SUM_OUT_W-1:0]   SUM_MAX   = '1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TEST,
      S_DIV,
      S_PW,
      S_CNT,
      S_SUM,
      S_NEXT,
      S_LEFT,
      S_LEFTMUL,
      S_FINISH
   } dcs_state_type;

   typedef struct packed {
      logic                   done;
      logic [NUMBER_BITS-1:0] quotient;
      logic [NUMBER_BITS-1:0] remainder;
   } dcs_div_rsp_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] product;
   } dcs_mul_rsp_type;

endpackage

/* rtl/dcs_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dcs_pkg.
module dcs_divider import dcs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUMBER_BITS-1:0] dividend,
   input  logic [NUMBER_BITS-1:0] divisor,
   output dcs_div_rsp_type        rsp
);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUMBER_BITS-1:0] rem_ff, rem_in;
   logic [NUMBER_BITS-1:0] quo_ff, quo_in;
   logic [NUMBER_BITS-1:0] dvs_ff, dvs_in;
   logic [NUMBER_BITS:0]   shifted;
   logic [NUMBER_BITS:0]   diff;
   logic                   ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUMBER_BITS-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         rem_in = ge ? diff[NUMBER_BITS-1:0] : shifted[NUMBER_BITS-1:0];
         quo_in = {quo_ff[NUMBER_BITS-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(NUMBER_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* rtl/dcs_multiplier.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle,
// finishing early once the remaining bits are zero. Depends on dcs_pkg.
module dcs_multiplier import dcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] op_a,
   input  logic [SUM_W-1:0] op_b,
   output dcs_mul_rsp_type  rsp
);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [SUM_W-1:0] a_ff, a_in;
   logic [SUM_W-1:0] b_ff, b_in;
   logic [SUM_W-1:0] acc_ff, acc_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in = 1'b1;
         a_in   = op_a;
         b_in   = op_b;
         acc_in = '0;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[SUM_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[SUM_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

/* rtl/divisor_count_and_sum_unit.sv */
// Divisor count and sum by trial division: controller plus bit-serial
// divider and multiplier. Depends on dcs_pkg, dcs_divider, dcs_multiplier.
//
//   channel  ports                                        handshake
//   request  start, busy, req_number[30:0]                start & !busy
//   result   rsp_strobe, rsp_divisor_count[10:0],         rsp_strobe, one cycle
//            rsp_divisor_sum[33:0]
//
// Each trial divisor costs at least one pass of the bit-serial divider, and
// each prime factor found adds multiplier passes. Zero is answered next cycle.
// Synchronous reset clears control; one result word per accepted word,
// and the receiver cannot stall it.
module divisor_count_and_sum_unit import dcs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [NUM_IN_W-1:0]    req_number,
   output logic                   rsp_strobe,
   output logic [COUNT_OUT_W-1:0] rsp_divisor_count,
   output logic [SUM_OUT_W-1:0]   rsp_divisor_sum
);

   dcs_state_type          state_ff, state_in;
   logic [NUMBER_BITS-1:0] n_ff, n_in;
   logic [NUMBER_BITS-1:0] d_ff, d_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [K_W-1:0]         k_ff, k_in;
   logic [SUM_W-1:0]       pw_ff, pw_in;
   logic [SUM_W-1:0]       part_ff, part_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [SUM_OUT_W-1:0]   rsp_sum_ff, rsp_sum_in;

   logic [NUMBER_BITS-1:0] next_d;
   logic [SQ_W-1:0]        next_sq;
   logic                   next_ok;
   logic                   div_start;
   logic                   mul_start;
   logic [SUM_W-1:0]       mul_a;
   logic [SUM_W-1:0]       mul_b;
   dcs_div_rsp_type        div_rsp;
   dcs_mul_rsp_type        mul_rsp;

   dcs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (d_in),
      .rsp      (div_rsp)
   );

   dcs_multiplier u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .rsp   (mul_rsp)
   );

   always_comb begin
      next_d  = (d_ff == NUMBER_BITS'(2)) ? NUMBER_BITS'(3) : d_ff + NUMBER_BITS'(2);
      next_sq = (d_ff == NUMBER_BITS'(2)) ? SQ_W'(9)
                : sq_ff + {d_ff, 2'b00} + SQ_W'(4);
      next_ok = next_sq <= SQ_W'(n_ff);

      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      pw_in        = pw_ff;
      part_in      = part_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_sum_in   = rsp_sum_ff;
      div_start    = 1'b0;
      mul_start    = 1'b0;
      mul_a        = sum_ff;
      mul_b        = part_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in = NUMBER_BITS'(req_number);
               if (n_in == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
                  rsp_sum_in   = '0;
               end else begin
                  count_in = CNT_W'(1);
                  sum_in   = SUM_W'(1);
                  d_in     = NUMBER_BITS'(2);
                  sq_in    = SQ_W'(4);
                  state_in = S_TEST;
               end
            end
         end
         S_TEST: begin
            if (sq_ff <= SQ_W'(n_ff)) begin
               k_in      = '0;
               pw_in     = SUM_W'(1);
               part_in   = SUM_W'(1);
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_LEFT;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0) begin
                  n_in      = div_rsp.quotient;
                  k_in      = k_ff + K_W'(1);
                  mul_start = 1'b1;
                  mul_a     = pw_ff;
                  mul_b     = SUM_W'(d_ff);
                  state_in  = S_PW;
               end else if (k_ff != '0) begin
                  mul_start = 1'b1;
                  mul_a     = SUM_W'(count_ff);
                  mul_b     = SUM_W'(k_ff) + SUM_W'(1);
                  state_in  = S_CNT;
               end else begin
                  d_in  = next_d;
                  sq_in = next_sq;
                  if (next_ok) begin
                     div_start = 1'b1;
                  end else begin
                     state_in = S_LEFT;
                  end
               end
            end
         end
         S_PW: begin
            if (mul_rsp.done) begin
               pw_in     = mul_rsp.product;
               part_in   = part_ff + mul_rsp.product;
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_CNT: begin
            if (mul_rsp.done) begin
               count_in  = CNT_W'(mul_rsp.product);
               mul_start = 1'b1;
               mul_a     = sum_ff;
               mul_b     = part_ff;
               state_in  = S_SUM;
            end
         end
         S_SUM: begin
            if (mul_rsp.done) begin
               sum_in   = mul_rsp.product;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            d_in  = next_d;
            sq_in = next_sq;
            if (next_ok) begin
               k_in      = '0;
               pw_in     = SUM_W'(1);
               part_in   = SUM_W'(1);
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_LEFT;
            end
         end
         S_LEFT: begin
            if (n_ff != NUMBER_BITS'(1)) begin
               count_in  = {count_ff[CNT_W-2:0], 1'b0};
               mul_start = 1'b1;
               mul_a     = sum_ff;
               mul_b     = SUM_W'(n_ff) + SUM_W'(1);
               state_in  = S_LEFTMUL;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_LEFTMUL: begin
            if (mul_rsp.done) begin
               sum_in   = mul_rsp.product;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = (count_ff > CNT_W'(COUNT_MAX)) ? COUNT_MAX
                           : COUNT_OUT_W'(count_ff);
            rsp_sum_in   = (WIDE_W'(sum_ff) > WIDE_W'(SUM_MAX)) ? SUM_MAX
                           : SUM_OUT_W'(sum_ff);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      count_ff     <= count_in;
      sum_ff       <= sum_in;
      k_ff         <= k_in;
      pw_ff        <= pw_in;
      part_ff      <= part_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_divisor_count = rsp_count_ff;
   assign rsp_divisor_sum   = rsp_sum_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_PW || state_ff == S_CNT ||
                        state_ff == S_SUM || state_ff == S_LEFTMUL))
      else $error("multiplier finished outside a multiply state");

   a_finish_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> rsp_strobe)
      else $error("finish without result strobe");

   a_unit_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_divisor_count == COUNT_OUT_W'(1))
         |-> (rsp_divisor_sum == SUM_OUT_W'(1)))
      else $error("single divisor with sum other than one");

endmodule
